@@ rtl/ins_sort_pkg.sv @@
// Shared types and constants for the insertion sorter.
package ins_sort_pkg;

  localparam int VALUE_W = 30;
  localparam int POS_W   = 6;

  // Saturation limit for incoming values
  localparam logic [VALUE_W-1:0] VALUE_LIMIT = VALUE_W'(1000000000);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic [POS_W-1:0]   position;
    logic               was_sorted;
    logic               last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_PLACE,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/ins_sort_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ins_sort_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/insertion_sorter_top.sv @@
// Insertion sorter: sorted store in RAM, shifted one entry per cycle by a small sequencer.
// An insertion keeps busy high while larger stored entries shift up (the first value of a
// set goes straight to ST_PLACE); the single RAM write port moves one entry a cycle.
// A closing item then emits its n values back to back, one per cycle, each read from the
// registered RAM port; a value arriving while the store is full is dropped.
// Synchronous reset empties the set; results cannot be stalled by the receiver.
module insertion_sorter_top #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  ins_sort_pkg::in_item_t   item,
  output ins_sort_pkg::out_item_t  result,
  output logic                     result_strobe
);
  import ins_sort_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic               order_kept, order_kept_next;
  logic [VALUE_W-1:0] prev_value, prev_value_next;
  logic [VALUE_W-1:0] ins_val, ins_val_next;
  logic               last_flag, last_flag_next;
  logic [AW-1:0]      j, j_next;
  logic [AW-1:0]      emit_idx, emit_idx_next;
  logic               out_pend, out_pend_next;
  logic [POS_W-1:0]   out_pos, out_pos_next;
  logic               out_sorted, out_sorted_next;
  logic               out_last, out_last_next;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic [VALUE_W-1:0] sat_val;
  logic               full;
  logic               is_final;

  ins_sort_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clamp the incoming value and flag a full store
  assign sat_val  = (item.value > VALUE_LIMIT) ? VALUE_LIMIT : item.value;
  assign full     = (count == CW'(MAX_ITEMS));
  assign is_final = ((CW'(emit_idx) + CW'(1)) == count);

  // Sequencer: next state, store access and result staging
  always_comb begin
    state_next      = state;
    count_next      = count;
    order_kept_next = order_kept;
    prev_value_next = prev_value;
    ins_val_next    = ins_val;
    last_flag_next  = last_flag;
    j_next          = j;
    emit_idx_next   = emit_idx;
    out_pend_next   = 1'b0;
    out_pos_next    = out_pos;
    out_sorted_next = out_sorted;
    out_last_next   = out_last;
    ram_we          = 1'b0;
    ram_waddr       = j;
    ram_wdata       = ins_val;
    ram_raddr       = j - AW'(1);

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (!full) begin
            if ((count != '0) && (sat_val < prev_value)) begin
              order_kept_next = 1'b0;
            end
            prev_value_next = sat_val;
            ins_val_next    = sat_val;
            last_flag_next  = item.last_in;
            j_next          = count[AW-1:0];
            count_next      = count + CW'(1);
            state_next      = (count == '0) ? ST_PLACE : ST_READ;
          end else if (item.last_in) begin
            // drop the value, still close the set
            emit_idx_next = '0;
            state_next    = ST_EMIT;
          end
        end
      end

      ST_READ: begin
        // fetch the entry just below the hole
        ram_raddr  = j - AW'(1);
        state_next = ST_CMP;
      end

      ST_CMP: begin
        if (ram_rdata > ins_val) begin
          // shift the larger entry up and fetch the next one down
          ram_we    = 1'b1;
          ram_waddr = j;
          ram_wdata = ram_rdata;
          ram_raddr = j - AW'(2);
          j_next    = j - AW'(1);
          if (j == AW'(1)) begin
            state_next = ST_PLACE;
          end
        end else begin
          ram_we        = 1'b1;
          ram_waddr     = j;
          ram_wdata     = ins_val;
          emit_idx_next = '0;
          state_next    = last_flag ? ST_EMIT : ST_IDLE;
        end
      end

      ST_PLACE: begin
        ram_we        = 1'b1;
        ram_waddr     = j;
        ram_wdata     = ins_val;
        emit_idx_next = '0;
        state_next    = last_flag ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        // read one entry per cycle; the result shows on the next cycle
        ram_raddr       = emit_idx;
        out_pend_next   = 1'b1;
        out_pos_next    = POS_W'(emit_idx);
        out_sorted_next = order_kept;
        out_last_next   = is_final;
        emit_idx_next   = emit_idx + AW'(1);
        if (is_final) begin
          count_next      = '0;
          order_kept_next = 1'b1;
          prev_value_next = '0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      order_kept <= 1'b1;
      prev_value <= '0;
      out_pend   <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      order_kept <= order_kept_next;
      prev_value <= prev_value_next;
      out_pend   <= out_pend_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ins_val    <= ins_val_next;
    last_flag  <= last_flag_next;
    j          <= j_next;
    emit_idx   <= emit_idx_next;
    out_pos    <= out_pos_next;
    out_sorted <= out_sorted_next;
    out_last   <= out_last_next;
  end

  // Drive the result transfer
  assign busy                = (state != ST_IDLE);
  assign result_strobe       = out_pend;
  assign result.sorted_value = ram_rdata;
  assign result.position     = out_pos;
  assign result.was_sorted   = out_sorted;
  assign result.last_out     = out_last;

endmodule

@@ rtl/ins_sort_chk.sv @@
// Port-level checker for the insertion sorter and its bind.
module ins_sort_chk (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input ins_sort_pkg::in_item_t  item,
  input ins_sort_pkg::out_item_t result,
  input logic                    result_strobe
);
  import ins_sort_pkg::*;

  // A result transfer always follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result strobe without preceding busy cycle");

  // A closing transfer always starts work
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last_in) |=> busy)
    else $error("closing item did not start work");

  // Results of a set come back to back with rising positions
  a_position_step: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last_out) |=>
      (result_strobe && (result.position == POS_W'($past(result.position) + POS_W'(1)))))
    else $error("result positions not contiguous");

  // Values within a set never decrease
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last_out) |=>
      (result.sorted_value >= $past(result.sorted_value)))
    else $error("results out of order");

  // The order flag is the same over a whole set
  a_flag_stable: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last_out) |=>
      (result.was_sorted == $past(result.was_sorted)))
    else $error("was_sorted changed within a set");

endmodule

bind insertion_sorter_top ins_sort_chk u_ins_sort_chk (.*);
